FILE: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared types and constants for the trial division prime test
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// width of the number under test, 8 to 64
	localparam int NUM_WIDTH = 32;
	// width of the candidate field on the input channel
	localparam int CAND_WIDTH = 32;
	// bit counter for one remainder pass
	localparam int CNT_WIDTH = $clog2(NUM_WIDTH);
	// running square of the divisor needs two bits of headroom
	localparam int SQ_WIDTH = NUM_WIDTH + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_TEST,
		ST_PRIME,
		ST_COMPOSITE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic next_div;
		logic res_load;
		logic res_val;
	} ctl_cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic n_eq2;
		logic n_even;
		logic bound_hit;
		logic div_last;
		logic rem_zero;
		logic out_busy;
	} dp_status_t;

endpackage

FILE: rtl/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// primality test by trial division over odd divisors
// ----------------------------------------------------------------------------
// usage
//   s_tdata carries one candidate per item; m_tdata bit 0 returns 1 when the
//   candidate (its low tdpt_pkg::NUM_WIDTH bits) is prime, one result per item
//   0 and 1 give 0, 2 gives 1, other even numbers give 0 straight away
//   odd numbers are divided by 3, 5, 7, ... while divisor squared <= number
// sequence
//   special cases and numbers below 9 are answered from the check state
//   otherwise each odd divisor tried takes a check step, a pass of the
//   bit-serial remainder unit (one bit a cycle) and its test step; a 32-bit
//   prime takes about 32768 divisors
// throughput
//   one item at a time; s_tready is high only while no item is in work
//   a finished result sits in the output register, so the next item is
//   taken while it waits; a further answer waits in the controller until
//   m_tready frees the register
// reset
//   arst_n returns the controller to idle and drops m_tvalid
// ----------------------------------------------------------------------------
module trial_division_prime_test_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] candidate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] prime_flag, [7:1] zero
);

	tdpt_pkg::ctl_cmd_t   cmd;
	tdpt_pkg::dp_status_t status;
	tdpt_pkg::state_t     state;
	logic                 prime_flag;

	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	tdpt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.candidate  (s_tdata),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.prime_flag (prime_flag),
		.out_ready  (m_tready)
	);

	assign m_tdata = {7'b0, prime_flag};

	// an accepted item leaves idle at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken twice without finishing");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while stalled");

	// remainder passes only run on odd numbers above two
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state == tdpt_pkg::ST_DIV) |-> (!status.n_even && !status.n_lt2))
		else $error("division started on a special case");

	// a result is loaded only from an answer state
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (state == tdpt_pkg::ST_PRIME || state == tdpt_pkg::ST_COMPOSITE))
		else $error("result loaded outside an answer state");

endmodule

FILE: rtl/tdpt_dp.sv
// ----------------------------------------------------------------------------
// tdpt_dp
// datapath: number, odd divisor, running square, bit-serial remainder
// unit and the result register
// ----------------------------------------------------------------------------
module tdpt_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tdpt_pkg::CAND_WIDTH-1:0]    candidate,
	input  tdpt_pkg::ctl_cmd_t                 cmd,
	output tdpt_pkg::dp_status_t               status,
	output logic                               out_valid,
	output logic                               prime_flag,
	input  logic                               out_ready
);

	logic [tdpt_pkg::NUM_WIDTH-1:0] n_q;
	logic [tdpt_pkg::NUM_WIDTH-1:0] d_q;
	logic [tdpt_pkg::SQ_WIDTH-1:0]  sq_q;
	logic [tdpt_pkg::NUM_WIDTH-1:0] rem_q;
	logic [tdpt_pkg::NUM_WIDTH-1:0] shift_q;
	logic [tdpt_pkg::CNT_WIDTH-1:0] cnt_q;
	logic                           out_valid_q;
	logic                           flag_q;

	logic [tdpt_pkg::NUM_WIDTH:0]   trial;
	logic [tdpt_pkg::NUM_WIDTH:0]   diff;
	logic [tdpt_pkg::NUM_WIDTH-1:0] rem_next;

	// one restoring step: bring down the next bit, subtract when it fits
	assign trial = {rem_q, shift_q[tdpt_pkg::NUM_WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};
	assign rem_next = diff[tdpt_pkg::NUM_WIDTH] ? trial[tdpt_pkg::NUM_WIDTH-1:0]
	                                            : diff[tdpt_pkg::NUM_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= tdpt_pkg::NUM_WIDTH'(candidate);
			d_q  <= tdpt_pkg::NUM_WIDTH'(3);
			sq_q <= tdpt_pkg::SQ_WIDTH'(9);
		end else if (cmd.next_div) begin
			// (d + 2)^2 = d^2 + 4d + 4
			d_q  <= d_q + tdpt_pkg::NUM_WIDTH'(2);
			sq_q <= sq_q + {d_q, 2'b00} + tdpt_pkg::SQ_WIDTH'(4);
		end
		if (cmd.div_start) begin
			rem_q   <= '0;
			shift_q <= n_q;
		end else if (cmd.div_step) begin
			rem_q   <= rem_next;
			shift_q <= {shift_q[tdpt_pkg::NUM_WIDTH-2:0], 1'b0};
		end
		if (cmd.res_load) begin
			flag_q <= cmd.res_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + tdpt_pkg::CNT_WIDTH'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.n_lt2     = (n_q < tdpt_pkg::NUM_WIDTH'(2));
	assign status.n_eq2     = (n_q == tdpt_pkg::NUM_WIDTH'(2));
	assign status.n_even    = ~n_q[0];
	assign status.bound_hit = (sq_q > {2'b00, n_q});
	assign status.div_last  = (cnt_q == tdpt_pkg::CNT_WIDTH'(tdpt_pkg::NUM_WIDTH - 1));
	assign status.rem_zero  = (rem_q == '0);
	assign status.out_busy  = out_valid_q & ~out_ready;

	assign out_valid  = out_valid_q;
	assign prime_flag = flag_q;

endmodule

FILE: rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// controller: sequences the special cases, the remainder passes and the
// hand-over of the answer to the result register
// ----------------------------------------------------------------------------
module tdpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tdpt_pkg::dp_status_t status,
	output tdpt_pkg::ctl_cmd_t   cmd,
	output tdpt_pkg::state_t     state
);

	tdpt_pkg::state_t state_q;
	tdpt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tdpt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tdpt_pkg::ST_CHECK;
				end
			end
			tdpt_pkg::ST_CHECK: begin
				if (status.n_lt2) begin
					state_d = tdpt_pkg::ST_COMPOSITE;
				end else if (status.n_eq2) begin
					state_d = tdpt_pkg::ST_PRIME;
				end else if (status.n_even) begin
					state_d = tdpt_pkg::ST_COMPOSITE;
				end else if (status.bound_hit) begin
					state_d = tdpt_pkg::ST_PRIME;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = tdpt_pkg::ST_DIV;
				end
			end
			tdpt_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = tdpt_pkg::ST_TEST;
				end
			end
			tdpt_pkg::ST_TEST: begin
				if (status.rem_zero) begin
					state_d = tdpt_pkg::ST_COMPOSITE;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = tdpt_pkg::ST_CHECK;
				end
			end
			tdpt_pkg::ST_PRIME: begin
				if (!status.out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b1;
					state_d      = tdpt_pkg::ST_IDLE;
				end
			end
			tdpt_pkg::ST_COMPOSITE: begin
				if (!status.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = tdpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdpt_pkg::ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule
